/* sv/enkp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// enkp_pkg
// Shared phase codes, result kinds, character constants and state/result
// structs for the escaped name key parser.
// ----------------------------------------------------------------------------
package enkp_pkg;

  // parse phases
  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_STRING = 3'd1;
  localparam logic [2:0] PH_COMP   = 3'd2;
  localparam logic [2:0] PH_ESC    = 3'd3;
  localparam logic [2:0] PH_HEX1   = 3'd4;
  localparam logic [2:0] PH_HEX2   = 3'd5;
  localparam logic [2:0] PH_CLOSED = 3'd6;
  localparam logic [2:0] PH_DROP   = 3'd7;

  // result kinds
  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_COMP   = 2'd1;
  localparam logic [1:0] KIND_ACCEPT = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  // characters
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_UA       = 8'h41;
  localparam logic [7:0] CH_UF       = 8'h46;
  localparam logic [7:0] CH_LA       = 8'h61;
  localparam logic [7:0] CH_LF       = 8'h66;
  localparam logic [7:0] CH_LX       = 8'h78;
  localparam logic [7:0] CH_UX       = 8'h58;
  localparam logic [7:0] CH_LN       = 8'h6E;
  localparam logic [7:0] CH_UN       = 8'h4E;
  localparam logic [7:0] CH_LR       = 8'h72;
  localparam logic [7:0] CH_UR       = 8'h52;
  localparam logic [7:0] CH_LT       = 8'h74;
  localparam logic [7:0] CH_UT       = 8'h54;

  localparam logic [7:0] COUNT_MAX   = 8'hFF;

  typedef struct packed {
    logic [2:0] phase;
    logic       resume_unique;
    logic [3:0] high_nibble;
    logic [7:0] component_count;
  } parse_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       unique_key;
    logic [7:0] index;
  } result_t;

endpackage
`default_nettype wire

/* sv/escaped_name_key_parser_unit.sv */
`default_nettype none
// Path: an accepted item reaches its result through the input register, then
// the result register; items that cause no result leave nothing behind.
// Throughput: one item per cycle unless results stall; combinational step.
// Reset: synchronous; clears both valids and returns the parser to the
// start of a name with no component counted.
// ----------------------------------------------------------------------------
// escaped_name_key_parser_unit
// Decodes a byte stream of escaped names into decoded bytes, component ends
// and an accept or reject per name.
// ----------------------------------------------------------------------------
module escaped_name_key_parser_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       name_end,
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic [1:0]      result_kind,
  output logic [7:0]      data_byte,
  output logic            key_is_unique,
  output logic [7:0]      component_index
);

  enkp_pkg::parse_state_t state;
  enkp_pkg::parse_state_t state_next;
  enkp_pkg::result_t      step_result;
  enkp_pkg::result_t      result;
  logic                   step_emit;

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_end;
  logic       fire;

  // the step runs when the result register is free or being emptied
  assign fire       = hold_valid && (!result_valid || !result_stall);
  assign item_stall = hold_valid && !fire;

  enkp_step u_step (
    .state      (state),
    .in_byte    (hold_byte),
    .name_end   (hold_end),
    .state_next (state_next),
    .emit       (step_emit),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      hold_byte <= in_byte;
      hold_end  <= name_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase           <= enkp_pkg::PH_START;
      state.resume_unique   <= 1'b0;
      state.high_nibble     <= 4'h0;
      state.component_count <= 8'h00;
    end else if (fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= step_emit;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && step_emit) begin
      result <= step_result;
    end
  end

  assign result_kind     = result.kind;
  assign data_byte       = result.data;
  assign key_is_unique   = result.unique_key;
  assign component_index = result.index;

`ifndef ASSERT_OFF
  a_count_only_in_keys: assert property (@(posedge clk) disable iff (rst)
    state.component_count != 8'h00 |-> state.resume_unique)
    else $error("component count set outside a bracketed key");

  a_string_index_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !key_is_unique |-> component_index == 8'h00)
    else $error("string key result carries a component index");

  a_drop_silent: assert property (@(posedge clk) disable iff (rst)
    fire && state.phase == enkp_pkg::PH_DROP |=> !result_valid)
    else $error("result produced while dropping a rejected name");

  a_accept_restarts: assert property (@(posedge clk) disable iff (rst)
    fire && step_emit && step_result.kind == enkp_pkg::KIND_ACCEPT
    |=> state.phase == enkp_pkg::PH_START)
    else $error("accepted name did not return to start of name");
`endif

endmodule
`default_nettype wire

/* sv/enkp_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// enkp_step
// One parse step: from the current state and one byte, the next state and
// at most one result.
// ----------------------------------------------------------------------------
module enkp_step (
  input  wire enkp_pkg::parse_state_t state,
  input  wire logic [7:0]             in_byte,
  input  wire logic                   name_end,
  output enkp_pkg::parse_state_t      state_next,
  output logic                        emit,
  output enkp_pkg::result_t           result
);

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = 5'h10;
    if (c >= enkp_pkg::CH_ZERO && c <= enkp_pkg::CH_NINE) begin
      d = {1'b0, 4'(c - enkp_pkg::CH_ZERO)};
    end else if (c >= enkp_pkg::CH_UA && c <= enkp_pkg::CH_UF) begin
      d = {1'b0, 4'(c - enkp_pkg::CH_UA + 8'd10)};
    end else if (c >= enkp_pkg::CH_LA && c <= enkp_pkg::CH_LF) begin
      d = {1'b0, 4'(c - enkp_pkg::CH_LA + 8'd10)};
    end
    return d;
  endfunction

  enkp_pkg::parse_state_t st;
  logic       do_string;
  logic       bump;
  logic [1:0] kind;
  logic [7:0] data;
  logic [4:0] digit;

  always_comb begin
    st        = state;
    do_string = 1'b0;
    bump      = 1'b0;
    emit      = 1'b0;
    kind      = enkp_pkg::KIND_BYTE;
    data      = 8'h00;
    digit     = hex_digit(in_byte);

    unique case (state.phase)
      enkp_pkg::PH_START: begin
        st.component_count = 8'h00;
        st.high_nibble     = 4'h0;
        if (name_end) begin
          st.resume_unique = 1'b0;
          emit = 1'b1;
          kind = enkp_pkg::KIND_ACCEPT;
        end else if (in_byte == enkp_pkg::CH_LBRACKET) begin
          st.resume_unique = 1'b1;
          st.phase         = enkp_pkg::PH_COMP;
        end else begin
          st.resume_unique = 1'b0;
          st.phase         = enkp_pkg::PH_STRING;
          do_string        = 1'b1;
        end
      end
      enkp_pkg::PH_STRING: begin
        do_string = 1'b1;
      end
      enkp_pkg::PH_COMP: begin
        if (name_end) begin
          emit = 1'b1;
          kind = enkp_pkg::KIND_REJECT;
          st.phase = enkp_pkg::PH_START;
        end else if (in_byte == enkp_pkg::CH_LBRACKET) begin
          emit = 1'b1;
          kind = enkp_pkg::KIND_REJECT;
          st.phase = enkp_pkg::PH_DROP;
        end else if (in_byte == enkp_pkg::CH_BSLASH) begin
          st.phase = enkp_pkg::PH_ESC;
        end else if (in_byte == enkp_pkg::CH_DOT) begin
          emit = 1'b1;
          kind = enkp_pkg::KIND_COMP;
          bump = 1'b1;
        end else if (in_byte == enkp_pkg::CH_RBRACKET) begin
          emit = 1'b1;
          kind = enkp_pkg::KIND_COMP;
          st.phase = enkp_pkg::PH_CLOSED;
        end else begin
          emit = 1'b1;
          data = in_byte;
        end
      end
      enkp_pkg::PH_ESC: begin
        if (name_end) begin
          emit = 1'b1;
          kind = enkp_pkg::KIND_REJECT;
          st.phase = enkp_pkg::PH_START;
        end else begin
          st.phase = state.resume_unique ? enkp_pkg::PH_COMP : enkp_pkg::PH_STRING;
          emit = 1'b1;
          case (in_byte) inside
            enkp_pkg::CH_LX, enkp_pkg::CH_UX: begin
              emit = 1'b0;
              st.phase = enkp_pkg::PH_HEX1;
            end
            enkp_pkg::CH_LN, enkp_pkg::CH_UN: data = enkp_pkg::CH_NL;
            enkp_pkg::CH_LR, enkp_pkg::CH_UR: data = enkp_pkg::CH_CR;
            enkp_pkg::CH_LT, enkp_pkg::CH_UT: data = enkp_pkg::CH_TAB;
            enkp_pkg::CH_ZERO:                data = enkp_pkg::CH_NUL;
            enkp_pkg::CH_BSLASH, enkp_pkg::CH_DOT,
            enkp_pkg::CH_LBRACKET, enkp_pkg::CH_RBRACKET: data = in_byte;
            default: begin
              kind = enkp_pkg::KIND_REJECT;
              st.phase = enkp_pkg::PH_DROP;
            end
          endcase
        end
      end
      enkp_pkg::PH_HEX1, enkp_pkg::PH_HEX2: begin
        if (name_end) begin
          emit = 1'b1;
          kind = enkp_pkg::KIND_REJECT;
          st.phase = enkp_pkg::PH_START;
        end else if (digit[4]) begin
          emit = 1'b1;
          kind = enkp_pkg::KIND_REJECT;
          st.phase = enkp_pkg::PH_DROP;
        end else if (state.phase == enkp_pkg::PH_HEX1) begin
          st.high_nibble = digit[3:0];
          st.phase = enkp_pkg::PH_HEX2;
        end else begin
          st.phase = state.resume_unique ? enkp_pkg::PH_COMP : enkp_pkg::PH_STRING;
          emit = 1'b1;
          data = {state.high_nibble, digit[3:0]};
        end
      end
      enkp_pkg::PH_CLOSED: begin
        emit = 1'b1;
        if (name_end) begin
          kind = enkp_pkg::KIND_ACCEPT;
          st.phase = enkp_pkg::PH_START;
        end else begin
          kind = enkp_pkg::KIND_REJECT;
          st.phase = enkp_pkg::PH_DROP;
        end
      end
      enkp_pkg::PH_DROP: begin
        if (name_end) begin
          st.phase = enkp_pkg::PH_START;
        end
      end
      default: begin
        st.phase = enkp_pkg::PH_START;
      end
    endcase

    // string body, also reached straight from the start of a name
    if (do_string) begin
      if (name_end) begin
        emit = 1'b1;
        kind = enkp_pkg::KIND_ACCEPT;
        st.phase = enkp_pkg::PH_START;
      end else if (in_byte == enkp_pkg::CH_LBRACKET || in_byte == enkp_pkg::CH_RBRACKET ||
                   in_byte == enkp_pkg::CH_DOT) begin
        emit = 1'b1;
        kind = enkp_pkg::KIND_REJECT;
        st.phase = enkp_pkg::PH_DROP;
      end else if (in_byte == enkp_pkg::CH_BSLASH) begin
        st.phase = enkp_pkg::PH_ESC;
      end else begin
        emit = 1'b1;
        data = in_byte;
      end
    end

    result.kind       = kind;
    result.data       = (kind == enkp_pkg::KIND_BYTE) ? data : 8'h00;
    result.unique_key = st.resume_unique;
    result.index      = st.resume_unique ? st.component_count : 8'h00;

    // advance the component count after the result has taken its index
    state_next = st;
    if (bump && st.component_count != enkp_pkg::COUNT_MAX) begin
      state_next.component_count = st.component_count + 8'd1;
    end
  end

endmodule
`default_nettype wire

/* sim/escaped_name_key_parser_unit_tb.sv */
// ----------------------------------------------------------------------------
// escaped_name_key_parser_unit_tb
// Feeds escaped names, both plain string keys and bracketed component keys,
// one character per item. A behavioural decoder predicts every decoded byte,
// component end, acceptance and rejection, and each result is checked in
// order. Runs directed names, a component count past saturation and random
// well-formed and broken names under three patterns of sender and receiver
// idling.
// ----------------------------------------------------------------------------
module escaped_name_key_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          IDLE_LIMIT   = 2000;
  localparam int          DRAIN_CYCLES = 10;
  localparam int          RANDOM_ITEMS = 480;
  localparam logic [4:0]  NO_DIGIT     = 5'd16;

  bit         clk;
  logic       rst          = 1'b1;
  logic       item_valid   = 1'b0;
  logic       item_stall;
  logic [7:0] in_byte      = 8'h00;
  logic       name_end     = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [1:0] result_kind;
  logic [7:0] data_byte;
  logic       key_is_unique;
  logic [7:0] component_index;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int error_count    = 0;
  int idle_cycles    = 0;

  // decoder state, kept in step with the block
  logic [2:0] key_phase  = enkp_pkg::PH_START;
  logic       key_unique = 1'b0;
  logic [3:0] key_nibble = 4'h0;
  logic [7:0] key_comp   = 8'h00;

  enkp_pkg::result_t pending_results[$];
  logic [7:0]        name_bytes[$];

  escaped_name_key_parser_unit dut (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .in_byte         (in_byte),
    .name_end        (name_end),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result_kind     (result_kind),
    .data_byte       (data_byte),
    .key_is_unique   (key_is_unique),
    .component_index (component_index)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------- decoder

  function automatic enkp_pkg::result_t key_result(input logic [1:0] kind,
                                                   input logic [7:0] data);
    enkp_pkg::result_t r;
    r.kind       = kind;
    r.data       = data;
    r.unique_key = key_unique;
    r.index      = key_unique ? key_comp : 8'h00;
    return r;
  endfunction

  // a terminator ends the name at once; anything else drops until one arrives
  function automatic enkp_pkg::result_t reject_name(input logic at_end);
    enkp_pkg::result_t r;
    r = key_result(enkp_pkg::KIND_REJECT, 8'h00);
    key_phase = at_end ? enkp_pkg::PH_START : enkp_pkg::PH_DROP;
    return r;
  endfunction

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    if (c >= enkp_pkg::CH_ZERO && c <= enkp_pkg::CH_NINE) return {1'b0, c[3:0]};
    if ((c >= enkp_pkg::CH_UA && c <= enkp_pkg::CH_UF) ||
        (c >= enkp_pkg::CH_LA && c <= enkp_pkg::CH_LF)) return 5'(c[3:0] + 4'd9);
    return NO_DIGIT;
  endfunction

  function automatic bit decode_char(input logic [7:0] c, input logic e,
                                     output enkp_pkg::result_t r);
    logic [4:0] d;
    bit         hit;
    r   = '0;
    hit = 1'b1;
    if (key_phase == enkp_pkg::PH_START) begin
      key_comp   = 8'h00;
      key_nibble = 4'h0;
      if (e) begin
        key_unique = 1'b0;
        r = key_result(enkp_pkg::KIND_ACCEPT, 8'h00);
        return 1'b1;
      end
      if (c == enkp_pkg::CH_LBRACKET) begin
        key_unique = 1'b1;
        key_phase  = enkp_pkg::PH_COMP;
        return 1'b0;
      end
      // the first byte belongs to the string body
      key_unique = 1'b0;
      key_phase  = enkp_pkg::PH_STRING;
    end
    case (key_phase)
      enkp_pkg::PH_STRING: begin
        if (e) begin
          key_phase = enkp_pkg::PH_START;
          r = key_result(enkp_pkg::KIND_ACCEPT, 8'h00);
        end else if (c == enkp_pkg::CH_LBRACKET || c == enkp_pkg::CH_RBRACKET ||
                     c == enkp_pkg::CH_DOT) begin
          r = reject_name(e);
        end else if (c == enkp_pkg::CH_BSLASH) begin
          key_phase = enkp_pkg::PH_ESC;
          hit = 1'b0;
        end else begin
          r = key_result(enkp_pkg::KIND_BYTE, c);
        end
      end
      enkp_pkg::PH_COMP: begin
        if (e || c == enkp_pkg::CH_LBRACKET) begin
          r = reject_name(e);
        end else if (c == enkp_pkg::CH_BSLASH) begin
          key_phase = enkp_pkg::PH_ESC;
          hit = 1'b0;
        end else if (c == enkp_pkg::CH_DOT) begin
          r = key_result(enkp_pkg::KIND_COMP, 8'h00);
          if (key_comp != enkp_pkg::COUNT_MAX) key_comp = key_comp + 8'd1;
        end else if (c == enkp_pkg::CH_RBRACKET) begin
          key_phase = enkp_pkg::PH_CLOSED;
          r = key_result(enkp_pkg::KIND_COMP, 8'h00);
        end else begin
          r = key_result(enkp_pkg::KIND_BYTE, c);
        end
      end
      enkp_pkg::PH_ESC: begin
        if (e) begin
          r = reject_name(e);
        end else begin
          key_phase = key_unique ? enkp_pkg::PH_COMP : enkp_pkg::PH_STRING;
          case (c)
            enkp_pkg::CH_LX, enkp_pkg::CH_UX: begin
              key_phase = enkp_pkg::PH_HEX1;
              hit = 1'b0;
            end
            enkp_pkg::CH_LN, enkp_pkg::CH_UN:
              r = key_result(enkp_pkg::KIND_BYTE, enkp_pkg::CH_NL);
            enkp_pkg::CH_LR, enkp_pkg::CH_UR:
              r = key_result(enkp_pkg::KIND_BYTE, enkp_pkg::CH_CR);
            enkp_pkg::CH_LT, enkp_pkg::CH_UT:
              r = key_result(enkp_pkg::KIND_BYTE, enkp_pkg::CH_TAB);
            enkp_pkg::CH_ZERO:
              r = key_result(enkp_pkg::KIND_BYTE, enkp_pkg::CH_NUL);
            enkp_pkg::CH_BSLASH, enkp_pkg::CH_DOT,
            enkp_pkg::CH_LBRACKET, enkp_pkg::CH_RBRACKET:
              r = key_result(enkp_pkg::KIND_BYTE, c);
            default: r = reject_name(e);
          endcase
        end
      end
      enkp_pkg::PH_HEX1: begin
        d = hex_value(c);
        if (e || d == NO_DIGIT) begin
          r = reject_name(e);
        end else begin
          key_nibble = d[3:0];
          key_phase  = enkp_pkg::PH_HEX2;
          hit = 1'b0;
        end
      end
      enkp_pkg::PH_HEX2: begin
        d = hex_value(c);
        if (e || d == NO_DIGIT) begin
          r = reject_name(e);
        end else begin
          key_phase = key_unique ? enkp_pkg::PH_COMP : enkp_pkg::PH_STRING;
          r = key_result(enkp_pkg::KIND_BYTE, {key_nibble, d[3:0]});
        end
      end
      enkp_pkg::PH_CLOSED: begin
        if (e) begin
          key_phase = enkp_pkg::PH_START;
          r = key_result(enkp_pkg::KIND_ACCEPT, 8'h00);
        end else begin
          r = reject_name(e);
        end
      end
      default: begin
        if (e) key_phase = enkp_pkg::PH_START;
        hit = 1'b0;
      end
    endcase
    return hit;
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic send_item(input logic [7:0] b, input logic e);
    enkp_pkg::result_t r;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    in_byte    <= b;
    name_end   <= e;
    do @(posedge clk); while (item_stall);
    if (decode_char(b, e, r)) pending_results.push_back(r);
    items_sent++;
  endtask

  // send the collected characters, then a terminator with a random dummy byte
  task automatic send_name();
    foreach (name_bytes[i]) send_item(name_bytes[i], 1'b0);
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == enkp_pkg::CH_LBRACKET || c == enkp_pkg::CH_RBRACKET ||
           c == enkp_pkg::CH_DOT || c == enkp_pkg::CH_BSLASH);
    return c;
  endfunction

  function automatic logic [7:0] special_char();
    case ($urandom_range(4))
      0:       return enkp_pkg::CH_LBRACKET;
      1:       return enkp_pkg::CH_RBRACKET;
      2:       return enkp_pkg::CH_DOT;
      3:       return enkp_pkg::CH_BSLASH;
      default: return enkp_pkg::CH_LX;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return enkp_pkg::CH_ZERO + 8'(v);
    return ($urandom_range(1) ? enkp_pkg::CH_UA : enkp_pkg::CH_LA) + 8'(v) - 8'd10;
  endfunction

  function automatic void push_escape();
    name_bytes.push_back(enkp_pkg::CH_BSLASH);
    case ($urandom_range(12))
      0, 1: begin
        name_bytes.push_back($urandom_range(1) ? enkp_pkg::CH_LX : enkp_pkg::CH_UX);
        name_bytes.push_back(hex_char(4'($urandom_range(15))));
        name_bytes.push_back(hex_char(4'($urandom_range(15))));
      end
      2:       name_bytes.push_back(enkp_pkg::CH_LN);
      3:       name_bytes.push_back(enkp_pkg::CH_UN);
      4:       name_bytes.push_back(enkp_pkg::CH_LR);
      5:       name_bytes.push_back(enkp_pkg::CH_UR);
      6:       name_bytes.push_back(enkp_pkg::CH_LT);
      7:       name_bytes.push_back(enkp_pkg::CH_UT);
      8:       name_bytes.push_back(enkp_pkg::CH_ZERO);
      9:       name_bytes.push_back(enkp_pkg::CH_BSLASH);
      10:      name_bytes.push_back(enkp_pkg::CH_DOT);
      11:      name_bytes.push_back(enkp_pkg::CH_LBRACKET);
      default: name_bytes.push_back(enkp_pkg::CH_RBRACKET);
    endcase
  endfunction

  function automatic void push_body();
    int n;
    n = $urandom_range(8);
    repeat (n) begin
      if ($urandom_range(3) == 0) push_escape();
      else name_bytes.push_back(plain_char());
    end
  endfunction

  // mostly well-formed names; the rest carry a stray byte, stop short or are noise
  task automatic send_random_name();
    int mode;
    int ncomp;
    int cut;
    name_bytes.delete();
    mode = $urandom_range(9);
    if (mode == 9) begin
      if ($urandom_range(1)) name_bytes.push_back(enkp_pkg::CH_LBRACKET);
      repeat ($urandom_range(10)) begin
        if ($urandom_range(3) == 0) name_bytes.push_back(special_char());
        else name_bytes.push_back(8'($urandom_range(255)));
      end
    end else begin
      if ($urandom_range(1)) begin
        name_bytes.push_back(enkp_pkg::CH_LBRACKET);
        ncomp = $urandom_range(4);
        for (int i = 0; i < ncomp; i++) begin
          if (i > 0) name_bytes.push_back(enkp_pkg::CH_DOT);
          push_body();
        end
        name_bytes.push_back(enkp_pkg::CH_RBRACKET);
      end else begin
        push_body();
      end
      if (mode == 7) begin
        name_bytes.insert($urandom_range(name_bytes.size()), special_char());
      end else if (mode == 8 && name_bytes.size() > 0) begin
        cut = $urandom_range(name_bytes.size() - 1);
        while (name_bytes.size() > cut) void'(name_bytes.pop_back());
      end
    end
    send_name();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_names();
    // empty name
    name_bytes = {};
    send_name();
    // byte extremes and both cases of hex digit in a string key
    name_bytes = {8'h00, 8'hFF, enkp_pkg::CH_BSLASH, enkp_pkg::CH_UX,
                  enkp_pkg::CH_LA, enkp_pkg::CH_UF};
    send_name();
    // empty components and an escaped closing bracket
    name_bytes = {enkp_pkg::CH_LBRACKET, enkp_pkg::CH_DOT, enkp_pkg::CH_BSLASH,
                  enkp_pkg::CH_RBRACKET, enkp_pkg::CH_RBRACKET};
    send_name();
    // unknown escape letter, then drop to the terminator
    name_bytes = {enkp_pkg::CH_BSLASH, 8'h71, 8'h7A};
    send_name();
    // terminator inside an unclosed bracketed key
    name_bytes = {enkp_pkg::CH_LBRACKET, enkp_pkg::CH_LA};
    send_name();
    // byte after the closing bracket
    name_bytes = {enkp_pkg::CH_LBRACKET, enkp_pkg::CH_RBRACKET, 8'h62};
    send_name();
  endtask

  task automatic test_component_overflow();
    name_bytes = {enkp_pkg::CH_LBRACKET};
    repeat (300) name_bytes.push_back(enkp_pkg::CH_DOT);
    name_bytes.push_back(plain_char());
    name_bytes.push_back(enkp_pkg::CH_RBRACKET);
    send_name();
  endtask

  task automatic test_random_names(input int send_pct, input int recv_pct, input int n);
    int target;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    target = items_sent + n;
    while (items_sent < target) send_random_name();
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    enkp_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("unexpected result: kind %0d data %02h unique %0d index %0d",
                               result_kind, data_byte, key_is_unique, component_index));
      end else begin
        want = pending_results.pop_front();
        if (want.kind !== result_kind || want.data !== data_byte ||
            want.unique_key !== key_is_unique || want.index !== component_index) begin
          report_error($sformatf(
            "mismatch: want kind %0d data %02h unique %0d index %0d, got %0d %02h %0d %0d",
            want.kind, want.data, want.unique_key, want.index,
            result_kind, data_byte, key_is_unique, component_index));
        end
      end
    end
  end

  // end the run when no item moves on either side for too long
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct  = 19;
    recv_stall_pct = 86;
    test_directed_names();
    test_component_overflow();
    test_random_names(19, 86, RANDOM_ITEMS);
    test_random_names(86, 19, RANDOM_ITEMS);
    test_random_names(0, 0, RANDOM_ITEMS);
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
sv/enkp_pkg.sv
sv/enkp_step.sv
sv/escaped_name_key_parser_unit.sv
sim/escaped_name_key_parser_unit_tb.sv
